/* design/mbrd_pkg.sv */
`timescale 1ns / 1ps

package mbrd_pkg;

    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_BYTE  = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    localparam logic [1:0] KIND_REQ    = 2'd0;
    localparam logic [1:0] KIND_VALUE  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_NO_RESPONSE = 4'd1;
    localparam logic [3:0] ST_TRANSACTION = 4'd2;
    localparam logic [3:0] ST_PROTOCOL    = 4'd3;
    localparam logic [3:0] ST_UNIT        = 4'd4;
    localparam logic [3:0] ST_SHORT_LEN   = 4'd5;
    localparam logic [3:0] ST_LONG_PDU    = 4'd6;
    localparam logic [3:0] ST_NO_PDU      = 4'd7;
    localparam logic [3:0] ST_EXCEPTION   = 4'd8;
    localparam logic [3:0] ST_FUNCTION    = 4'd9;
    localparam logic [3:0] ST_BYTE_COUNT  = 4'd10;

    localparam int          NUM_FLAGS      = 10;
    localparam logic [7:0]  MBAP_LEN_LO    = 8'h06;
    localparam logic [7:0]  EXC_MASK       = 8'h80;
    localparam logic [15:0] PDU_LEN_MAX    = 16'd254;
    localparam logic [15:0] PDU_LEN_MIN    = 16'd2;
    localparam logic [15:0] TIMEOUT_RESET  = 16'd2000;
    localparam logic [3:0]  REQ_LAST_STEP  = 4'd11;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    typedef struct packed {
        logic        req;
        logic        val;
        logic        stat;
        logic [15:0] data;
        logic [7:0]  unit;
        logic [7:0]  fc;
        logic [15:0] addr;
        logic [6:0]  qty;
        logic [3:0]  status;
        logic [7:0]  detail;
    } t_job;

endpackage

/* design/mbrd_queue.sv */
`timescale 1ns / 1ps

module mbrd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mbrd_pkg::t_job i_push_job,
    output logic          o_full,
    input  logic          i_pop,
    output mbrd_pkg::t_job o_head_job,
    output logic          o_empty
);
    import mbrd_pkg::*;

    t_job             r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp;
    logic [QAW-1:0]   r_rp;
    logic [QAW:0]     r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full     = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_empty    = (r_cnt == '0);
    assign o_head_job = r_mem[r_rp];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* design/mbrd_front.sv */
`timescale 1ns / 1ps

module mbrd_front #(
    parameter int BUFFER_BYTES = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_wr_en,
    input  logic [15:0]    i_cfg_wr_data,
    input  logic           i_accept,
    input  logic [1:0]     i_func,
    input  logic [7:0]     i_unit_id,
    input  logic [7:0]     i_function_code,
    input  logic [15:0]    i_reg_addr,
    input  logic [6:0]     i_quantity,
    input  logic [7:0]     i_rx_byte,
    output logic           o_push,
    output mbrd_pkg::t_job o_job
);
    import mbrd_pkg::*;

    localparam int CMP_W = ($clog2(BUFFER_BYTES + 1) > 9) ? $clog2(BUFFER_BYTES + 1) : 9;

    logic [15:0]          r_timeout;
    logic [15:0]          r_tid,     n_tid;
    logic                 r_waiting, n_waiting;
    logic [7:0]           r_unit,    n_unit;
    logic [7:0]           r_fc,      n_fc;
    logic [6:0]           r_qty,     n_qty;
    logic [8:0]           r_rcvd,    n_rcvd;
    logic [15:0]          r_elapsed, n_elapsed;
    logic [7:0]           r_held,    n_held;
    logic [NUM_FLAGS-1:0] r_flags,   n_flags;
    logic [7:0]           r_detail,  n_detail;

    logic [CMP_W-1:0]     raw_total;
    logic [CMP_W-1:0]     frame_total;
    logic [15:0]          pdu_len;
    logic                 do_finish;
    logic [3:0]           fin_code;

    assign raw_total   = CMP_W'(9) + {{(CMP_W-8){1'b0}}, r_qty, 1'b0};
    assign frame_total = (raw_total > CMP_W'(BUFFER_BYTES)) ? CMP_W'(BUFFER_BYTES) : raw_total;
    assign pdu_len     = {r_held, i_rx_byte};

    always_comb begin
        fin_code = ST_OK;
        for (int i = NUM_FLAGS - 1; i >= 0; i--) begin
            if (n_flags[i]) begin
                fin_code = 4'(i + 1);
            end
        end
        if (fin_code == ST_OK) begin
            if (n_rcvd == '0) begin
                fin_code = ST_NO_RESPONSE;
            end else if (CMP_W'(n_rcvd) < frame_total) begin
                fin_code = ST_NO_PDU;
            end
        end
    end

    always_comb begin
        n_tid     = r_tid;
        n_waiting = r_waiting;
        n_unit    = r_unit;
        n_fc      = r_fc;
        n_qty     = r_qty;
        n_rcvd    = r_rcvd;
        n_elapsed = r_elapsed;
        n_held    = r_held;
        n_flags   = r_flags;
        n_detail  = r_detail;
        o_job     = '0;
        o_push    = 1'b0;
        do_finish = 1'b0;
        if (i_accept) begin
            case (i_func)
                FUNC_START: begin
                    n_tid      = r_tid + 16'd1;
                    n_waiting  = 1'b1;
                    n_unit     = i_unit_id;
                    n_fc       = i_function_code;
                    n_qty      = i_quantity;
                    n_rcvd     = '0;
                    n_elapsed  = '0;
                    n_held     = '0;
                    n_flags    = '0;
                    n_detail   = '0;
                    o_job.req  = 1'b1;
                    o_job.data = n_tid;
                    o_job.unit = i_unit_id;
                    o_job.fc   = i_function_code;
                    o_job.addr = i_reg_addr;
                    o_job.qty  = i_quantity;
                    o_push     = 1'b1;
                end
                FUNC_BYTE: begin
                    if (r_waiting) begin
                        case (r_rcvd)
                            9'd0, 9'd2, 9'd4: begin
                                n_held = i_rx_byte;
                            end
                            9'd1: begin
                                if (pdu_len != r_tid) begin
                                    n_flags[ST_TRANSACTION - 4'd1] = 1'b1;
                                end
                            end
                            9'd3: begin
                                if (pdu_len != 16'd0) begin
                                    n_flags[ST_PROTOCOL - 4'd1] = 1'b1;
                                end
                            end
                            9'd5: begin
                                if (pdu_len < PDU_LEN_MIN) begin
                                    n_flags[ST_SHORT_LEN - 4'd1] = 1'b1;
                                end else if (pdu_len > PDU_LEN_MAX) begin
                                    n_flags[ST_LONG_PDU - 4'd1] = 1'b1;
                                end
                            end
                            9'd6: begin
                                if (i_rx_byte != r_unit) begin
                                    n_flags[ST_UNIT - 4'd1] = 1'b1;
                                end
                            end
                            9'd7: begin
                                if ((i_rx_byte & EXC_MASK) != 8'd0) begin
                                    n_flags[ST_EXCEPTION - 4'd1] = 1'b1;
                                    n_detail = '0;
                                end else if (i_rx_byte != r_fc) begin
                                    n_flags[ST_FUNCTION - 4'd1] = 1'b1;
                                    n_detail = i_rx_byte;
                                end
                            end
                            9'd8: begin
                                if (r_flags[ST_EXCEPTION - 4'd1]) begin
                                    n_detail = i_rx_byte;
                                end else if (i_rx_byte != {r_qty, 1'b0}) begin
                                    n_flags[ST_BYTE_COUNT - 4'd1] = 1'b1;
                                end
                            end
                            default: begin
                                if (r_rcvd[0]) begin
                                    n_held = i_rx_byte;
                                end else if (r_flags == '0) begin
                                    o_job.val  = 1'b1;
                                    o_job.data = pdu_len;
                                    o_push     = 1'b1;
                                end
                            end
                        endcase
                        n_rcvd = r_rcvd + 9'd1;
                        if (CMP_W'(n_rcvd) >= frame_total) begin
                            do_finish = 1'b1;
                        end
                    end
                end
                FUNC_TICK: begin
                    if (r_waiting) begin
                        if (r_elapsed != 16'hFFFF) begin
                            n_elapsed = r_elapsed + 16'd1;
                        end
                        if (n_elapsed >= r_timeout) begin
                            do_finish = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        if (do_finish) begin
            n_waiting    = 1'b0;
            o_job.stat   = 1'b1;
            o_job.status = fin_code;
            o_job.detail = (fin_code == ST_EXCEPTION || fin_code == ST_FUNCTION) ?
                           n_detail : 8'd0;
            o_push       = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
            r_tid     <= '0;
            r_waiting <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_timeout <= i_cfg_wr_data;
            end
            r_tid     <= n_tid;
            r_waiting <= n_waiting;
        end
    end

    always_ff @(posedge i_clk) begin
        r_unit    <= n_unit;
        r_fc      <= n_fc;
        r_qty     <= n_qty;
        r_rcvd    <= n_rcvd;
        r_elapsed <= n_elapsed;
        r_held    <= n_held;
        r_flags   <= n_flags;
        r_detail  <= n_detail;
    end

endmodule

/* design/mbrd_back.sv */
`timescale 1ns / 1ps

module mbrd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mbrd_pkg::t_job i_head_job,
    input  logic           i_empty,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [1:0]     o_kind,
    output logic [15:0]    o_data,
    output logic [3:0]     o_status,
    output logic [7:0]     o_detail,
    output logic           o_last
);
    import mbrd_pkg::*;

    logic        r_valid;
    logic [1:0]  r_kind,   n_kind;
    logic [15:0] r_data,   n_data;
    logic [3:0]  r_status, n_status;
    logic [7:0]  r_detail, n_detail;
    logic        r_last,   n_last;
    logic [3:0]  r_step;
    logic        out_free;
    logic        emit;
    logic        job_done;
    logic [7:0]  req_byte;

    assign out_free = !r_valid || !i_out_stall;
    assign emit     = out_free && !i_empty;
    assign o_pop    = emit && job_done;

    always_comb begin
        case (r_step)
            4'd0:    req_byte = i_head_job.data[15:8];
            4'd1:    req_byte = i_head_job.data[7:0];
            4'd5:    req_byte = MBAP_LEN_LO;
            4'd6:    req_byte = i_head_job.unit;
            4'd7:    req_byte = i_head_job.fc;
            4'd8:    req_byte = i_head_job.addr[15:8];
            4'd9:    req_byte = i_head_job.addr[7:0];
            4'd11:   req_byte = {1'b0, i_head_job.qty};
            default: req_byte = 8'd0;
        endcase
    end

    always_comb begin
        n_kind   = KIND_STATUS;
        n_data   = 16'd0;
        n_status = i_head_job.status;
        n_detail = i_head_job.detail;
        n_last   = 1'b1;
        job_done = 1'b1;
        if (i_head_job.req) begin
            n_kind   = KIND_REQ;
            n_data   = {8'd0, req_byte};
            n_status = ST_OK;
            n_detail = 8'd0;
            n_last   = (r_step == REQ_LAST_STEP);
            job_done = n_last;
        end else if (i_head_job.val && r_step == 4'd0) begin
            n_kind   = KIND_VALUE;
            n_data   = i_head_job.data;
            n_status = ST_OK;
            n_detail = 8'd0;
            n_last   = 1'b0;
            job_done = !i_head_job.stat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= '0;
        end else if (out_free) begin
            r_valid <= !i_empty;
            if (emit) begin
                r_step <= job_done ? 4'd0 : r_step + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind   <= n_kind;
            r_data   <= n_data;
            r_status <= n_status;
            r_detail <= n_detail;
            r_last   <= n_last;
        end
    end

    assign o_out_valid = r_valid;
    assign o_kind      = r_kind;
    assign o_data      = r_data;
    assign o_status    = r_status;
    assign o_detail    = r_detail;
    assign o_last      = r_last;

endmodule

/* design/modbus_tcp_read_transaction_core.sv */
`timescale 1ns / 1ps

// Modbus TCP read transaction engine. A start word emits the twelve-byte request frame with a
// fresh transaction id; response bytes and millisecond ticks are then checked on the fly, each
// register value is emitted when its low byte arrives, and a status word with last set closes
// the transaction. Response bytes and ticks are taken one word per cycle; a start word occupies
// the output for twelve request words, and a four-entry job queue between the checker and the
// output sequencer absorbs the difference, so input stalls only when that queue is full.

module modbus_tcp_read_transaction_core #(
    parameter int BUFFER_BYTES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_unit_id,
    input  logic [7:0]  i_function_code,
    input  logic [15:0] i_reg_addr,
    input  logic [6:0]  i_quantity,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [15:0] o_data,
    output logic [3:0]  o_status,
    output logic [7:0]  o_detail,
    output logic        o_last
);
    import mbrd_pkg::*;

    t_job q_push_job;
    t_job q_head_job;
    logic q_push;
    logic q_full;
    logic q_empty;
    logic q_pop;
    logic in_accept;

    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !q_full;

    mbrd_front #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_accept       (in_accept),
        .i_func         (i_func),
        .i_unit_id      (i_unit_id),
        .i_function_code(i_function_code),
        .i_reg_addr     (i_reg_addr),
        .i_quantity     (i_quantity),
        .i_rx_byte      (i_rx_byte),
        .o_push         (q_push),
        .o_job          (q_push_job)
    );

    mbrd_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (q_push),
        .i_push_job(q_push_job),
        .o_full    (q_full),
        .i_pop     (q_pop),
        .o_head_job(q_head_job),
        .o_empty   (q_empty)
    );

    mbrd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head_job (q_head_job),
        .i_empty    (q_empty),
        .o_pop      (q_pop),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_kind     (o_kind),
        .o_data     (o_data),
        .o_status   (o_status),
        .o_detail   (o_detail),
        .o_last     (o_last)
    );

`ifndef ASSERT_OFF
    a_start_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_func == FUNC_START) |=> !q_empty)
        else $error("start word was not queued");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_STATUS) |-> o_last)
        else $error("status word without last");

    a_value_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_VALUE) |-> (!o_last && o_status == ST_OK))
        else $error("register value word carries last or status");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !q_push)
        else $error("job pushed into a full queue");
`endif

endmodule

/* tb/modbus_tcp_read_transaction_core_tb.sv */
`timescale 1ns / 1ps

module modbus_tcp_read_transaction_core_tb;

    import mbrd_pkg::*;

    localparam int BUF_BYTES = 256;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int ITEMS_PER_PHASE = 10;
    localparam int NUM_PHASES = 5;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] data;
        logic [3:0]  status;
        logic [7:0]  detail;
        logic        last;
    } out_word_t;

    class transaction_tracker;
        logic [15:0]          tick_limit;
        logic [15:0]          txn_id;
        bit                   waiting;
        logic [7:0]           exp_unit;
        logic [7:0]           exp_fc;
        logic [6:0]           exp_qty;
        logic [8:0]           rx_count;
        logic [15:0]          elapsed_ms;
        logic [7:0]           high_byte;
        logic [NUM_FLAGS-1:0] err_flags;
        logic [7:0]           err_detail;
        out_word_t            due_words[$];
        int                   mismatches;

        function new();
            tick_limit = TIMEOUT_RESET;
            txn_id     = '0;
            waiting    = 1'b0;
            exp_unit   = '0;
            exp_fc     = '0;
            exp_qty    = '0;
            rx_count   = '0;
            elapsed_ms = '0;
            high_byte  = '0;
            err_flags  = '0;
            err_detail = '0;
            mismatches = 0;
        endfunction

        function void emit(logic [1:0] kind, logic [15:0] data, logic [3:0] status,
                           logic [7:0] detail, logic last);
            out_word_t w;
            w.kind   = kind;
            w.data   = data;
            w.status = status;
            w.detail = detail;
            w.last   = last;
            due_words.push_back(w);
        endfunction

        function int unsigned frame_len();
            int unsigned n;
            n = 9 + 2 * exp_qty;
            if (n > BUF_BYTES) begin
                n = BUF_BYTES;
            end
            return n;
        endfunction

        function void raise_flag(logic [3:0] code);
            err_flags[code - 1] = 1'b1;
        endfunction

        function void close_out();
            logic [3:0] code;
            logic [7:0] det;
            code = ST_OK;
            det  = 8'h00;
            // The lowest failing check wins.
            for (int i = NUM_FLAGS - 1; i >= 0; i--) begin
                if (err_flags[i]) begin
                    code = 4'(i + 1);
                end
            end
            if (code == ST_OK) begin
                if (rx_count == 0) begin
                    code = ST_NO_RESPONSE;
                end else if (rx_count < frame_len()) begin
                    code = ST_NO_PDU;
                end
            end
            if (code == ST_EXCEPTION || code == ST_FUNCTION) begin
                det = err_detail;
            end
            emit(KIND_STATUS, 16'h0000, code, det, 1'b1);
            waiting = 1'b0;
        endfunction

        function void take_byte(logic [7:0] b);
            logic [15:0] word16;
            word16 = {high_byte, b};
            case (rx_count)
                9'd0, 9'd2, 9'd4: high_byte = b;
                9'd1: if (word16 != txn_id) raise_flag(ST_TRANSACTION);
                9'd3: if (word16 != 16'h0000) raise_flag(ST_PROTOCOL);
                9'd5: begin
                    if (word16 < PDU_LEN_MIN) begin
                        raise_flag(ST_SHORT_LEN);
                    end else if (word16 > PDU_LEN_MAX) begin
                        raise_flag(ST_LONG_PDU);
                    end
                end
                9'd6: if (b != exp_unit) raise_flag(ST_UNIT);
                9'd7: begin
                    if ((b & EXC_MASK) != 8'h00) begin
                        raise_flag(ST_EXCEPTION);
                        err_detail = 8'h00;
                    end else if (b != exp_fc) begin
                        raise_flag(ST_FUNCTION);
                        err_detail = b;
                    end
                end
                9'd8: begin
                    if (err_flags[ST_EXCEPTION - 1]) begin
                        err_detail = b;
                    end else if (b != {exp_qty, 1'b0}) begin
                        raise_flag(ST_BYTE_COUNT);
                    end
                end
                default: begin
                    if (rx_count[0]) begin
                        high_byte = b;
                    end else if (err_flags == '0) begin
                        emit(KIND_VALUE, word16, ST_OK, 8'h00, 1'b0);
                    end
                end
            endcase
            rx_count = rx_count + 9'd1;
            if (rx_count >= frame_len()) begin
                close_out();
            end
        endfunction

        // Returns 1 when the word has an effect on the transaction.
        function bit note_word(logic [1:0] func, logic [7:0] unit, logic [7:0] fc,
                               logic [15:0] addr, logic [6:0] qty, logic [7:0] rxb);
            logic [7:0] req[12];
            if (func == FUNC_START) begin
                txn_id = txn_id + 16'd1;
                req = '{txn_id[15:8], txn_id[7:0], 8'h00, 8'h00, 8'h00, MBAP_LEN_LO,
                        unit, fc, addr[15:8], addr[7:0], 8'h00, {1'b0, qty}};
                for (int i = 0; i < 12; i++) begin
                    emit(KIND_REQ, {8'h00, req[i]}, ST_OK, 8'h00, i == REQ_LAST_STEP);
                end
                waiting    = 1'b1;
                exp_unit   = unit;
                exp_fc     = fc;
                exp_qty    = qty;
                rx_count   = '0;
                elapsed_ms = '0;
                high_byte  = '0;
                err_flags  = '0;
                err_detail = '0;
                return 1'b1;
            end
            if (!waiting || func == FUNC_UNUSED) begin
                return 1'b0;
            end
            if (func == FUNC_BYTE) begin
                take_byte(rxb);
            end else begin
                if (elapsed_ms != 16'hFFFF) begin
                    elapsed_ms = elapsed_ms + 16'd1;
                end
                if (elapsed_ms >= tick_limit) begin
                    close_out();
                end
            end
            return 1'b1;
        endfunction

        function void report(string what, out_word_t want, out_word_t got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%s: expected kind %0d data %h status %0d detail %h last %0d,",
                         what, want.kind, want.data, want.status, want.detail, want.last);
                $display("    got kind %0d data %h status %0d detail %h last %0d",
                         got.kind, got.data, got.status, got.detail, got.last);
            end
        endfunction

        function void check_word(out_word_t got);
            out_word_t want;
            if (due_words.size() == 0) begin
                report("unexpected word", '0, got);
                return;
            end
            want = due_words.pop_front();
            if (got.kind !== want.kind || got.data !== want.data ||
                got.status !== want.status || got.detail !== want.detail ||
                got.last !== want.last) begin
                report("wrong word", want, got);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  func = '0;
    logic [7:0]  unit_id = '0;
    logic [7:0]  function_code = '0;
    logic [15:0] reg_addr = '0;
    logic [6:0]  quantity = '0;
    logic [7:0]  rx_byte = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [15:0] data;
    logic [3:0]  status;
    logic [7:0]  detail;
    logic        last;

    transaction_tracker tracker = new();
    out_word_t seen_words[$];
    int burst_left = 1;
    int items_taken = 0;
    int stall_mode = 0;
    int stall_left = 0;
    int stall_tick = 0;

    modbus_tcp_read_transaction_core #(
        .BUFFER_BYTES(BUF_BYTES)
    ) i_dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_cfg_wr_en(cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_in_valid(in_valid),
        .o_in_stall(in_stall),
        .i_func(func),
        .i_unit_id(unit_id),
        .i_function_code(function_code),
        .i_reg_addr(reg_addr),
        .i_quantity(quantity),
        .i_rx_byte(rx_byte),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_kind(kind),
        .o_data(data),
        .o_status(status),
        .o_detail(detail),
        .o_last(last)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ((stall_tick % 7) < 2);
        endcase
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            seen_words.push_back({kind, data, status, detail, last});
        end
    end

    // Results are compared on the falling edge, once the rising edge before it has noted its input word.
    always @(negedge clk) begin
        while (seen_words.size() != 0) begin
            tracker.check_word(seen_words.pop_front());
        end
    end

    task automatic send_word(input logic [1:0] f, input logic [7:0] u, input logic [7:0] fc,
                             input logic [15:0] a, input logic [6:0] q, input logic [7:0] b);
        int gap;
        in_valid      <= 1'b1;
        func          <= f;
        unit_id       <= u;
        function_code <= fc;
        reg_addr      <= a;
        quantity      <= q;
        rx_byte       <= b;
        do @(posedge clk); while (in_stall);
        if (tracker.note_word(f, u, fc, a, q, b)) begin
            items_taken++;
        end
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_start(input logic [7:0] u, input logic [7:0] fc, input logic [15:0] a,
                              input logic [6:0] q);
        send_word(FUNC_START, u, fc, a, q, 8'($urandom));
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_word(FUNC_BYTE, 8'($urandom), 8'($urandom), 16'($urandom), 7'($urandom), b);
    endtask

    task automatic send_tick();
        send_word(FUNC_TICK, 8'($urandom), 8'($urandom), 16'($urandom), 7'($urandom),
                  8'($urandom));
    endtask

    task automatic drain_replies(input int extra);
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.due_words.size() != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [15:0] value);
        drain_replies(60);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tracker.tick_limit = value;
    endtask

    task automatic send_reply(input logic [7:0] u, input logic [7:0] fc, input logic [6:0] q,
                              input int mode, input bit full);
        logic [7:0]  frame[$];
        logic [15:0] len;
        int total;
        int keep;
        int pos;
        int n;
        len = 16'd3 + {8'h00, q, 1'b0};
        total = 9 + 2 * q;
        if (total > BUF_BYTES) begin
            total = BUF_BYTES;
        end
        frame = {tracker.txn_id[15:8], tracker.txn_id[7:0], 8'h00, 8'h00, len[15:8], len[7:0],
                 u, fc, {q, 1'b0}};
        while (frame.size() < total) frame.push_back(8'($urandom));
        keep = total;
        case (mode)
            5: begin
                pos = $urandom_range(0, 8);
                frame[pos] = frame[pos] ^ 8'($urandom_range(1, 255));
                pos = $urandom_range(0, 8);
                frame[pos] = frame[pos] ^ 8'($urandom_range(1, 255));
            end
            6: begin
                pos = $urandom_range(0, 8);
                frame[pos] = frame[pos] ^ 8'($urandom_range(1, 255));
            end
            7: frame[7] = frame[7] | EXC_MASK;
            8: keep = $urandom_range(0, total - 1);
            9: begin
                frame[4] = 8'h00;
                frame[5] = 8'($urandom_range(0, 1));
            end
            default: ;
        endcase
        if (!full && keep > 40) begin
            keep = $urandom_range(0, 40);
        end
        for (int i = 0; i < keep; i++) begin
            if (!full && $urandom_range(0, 15) == 0) begin
                send_tick();
            end
            if (!tracker.waiting && $urandom_range(0, 3) != 0) begin
                break;
            end
            send_byte(frame[i]);
        end
        n = 0;
        while (tracker.waiting && n < 12) begin
            send_tick();
            n++;
        end
    endtask

    task automatic run_transaction(input bit force_cap);
        logic [7:0]  u;
        logic [7:0]  fc;
        logic [15:0] a;
        logic [6:0]  q;
        int noise;
        if ($urandom_range(0, 7) == 0) begin
            noise = $urandom_range(0, 2);
            if (noise == 0) begin
                send_byte(8'($urandom));
            end else if (noise == 1) begin
                send_tick();
            end else begin
                send_word(FUNC_UNUSED, 8'($urandom), 8'($urandom), 16'($urandom),
                          7'($urandom), 8'($urandom));
            end
        end
        u  = $urandom;
        fc = $urandom;
        a  = $urandom;
        if (force_cap) begin
            q = 7'd124 + 7'($urandom_range(0, 1));
        end else if ($urandom_range(0, 9) == 0) begin
            q = $urandom_range(0, 127);
        end else begin
            q = $urandom_range(0, 4);
        end
        send_start(u, fc, a, q);
        if (force_cap) begin
            send_reply(u, fc, q, 0, 1'b1);
        end else begin
            send_reply(u, fc, q, $urandom_range(0, 9), 1'b0);
        end
    endtask

    initial begin
        logic [15:0] phase_timeout[NUM_PHASES];
        phase_timeout = '{16'hFFFF, 16'd1, 16'($urandom_range(2, 10)), 16'd0, 16'd5};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Idle words are ignored, then a start with extreme fields is dropped by a second start.
        send_byte(8'hA5);
        send_tick();
        send_word(FUNC_UNUSED, 8'h5A, 8'hA5, 16'h5AA5, 7'h2A, 8'h5A);
        send_start(8'hFF, 8'hFF, 16'hFFFF, 7'h7F);
        send_start(8'h00, 8'h03, 16'h0000, 7'h00);
        send_reply(8'h00, 8'h03, 7'h00, 0, 1'b1);

        // With a zero timeout the first tick ends a silent transaction.
        cfg_write(16'h0000);
        send_start(8'h01, 8'h04, 16'h8001, 7'h01);
        send_tick();

        cfg_write(phase_timeout[0]);
        run_transaction(1'b1);
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph != 0) begin
                cfg_write(phase_timeout[ph]);
            end
            items_taken = 0;
            while (items_taken < ITEMS_PER_PHASE) begin
                run_transaction(1'b0);
                if ($urandom_range(0, 14) == 0) begin
                    drain_replies(0);
                end
            end
        end

        drain_replies(60);
        if (tracker.mismatches == 0 && tracker.due_words.size() == 0) begin
            $display("modbus_tcp_read_transaction_core test passed");
        end else begin
            $display("modbus_tcp_read_transaction_core test failed");
        end
        $finish;
    end

    initial begin
        #10000000;
        $display("modbus_tcp_read_transaction_core test failed");
        $finish;
    end

endmodule

/* modbus_tcp_read_transaction_core.f */
design/mbrd_pkg.sv
design/mbrd_queue.sv
design/mbrd_front.sv
design/mbrd_back.sv
design/modbus_tcp_read_transaction_core.sv
tb/modbus_tcp_read_transaction_core_tb.sv
